// File: sv/sset_pkg.sv
`default_nettype none

package sset_pkg;

    // fixed field widths
    localparam int IN_W    = 32;
    localparam int CFG_W   = 32;
    localparam int OUT_W   = 40;
    localparam int PADDR_W = 3;
    localparam int N_STATS = 4;

    // register index, taken from paddr[2]
    localparam logic [0:0] REG_REPEAT_COUNT = 1'b0;

    // statistic slots, in output order
    localparam logic [1:0] STAT_MIN = 2'd0;
    localparam logic [1:0] STAT_Q1  = 2'd1;
    localparam logic [1:0] STAT_MED = 2'd2;
    localparam logic [1:0] STAT_Q3  = 2'd3;

    typedef struct packed {
        logic [IN_W-1:0] sample;
        logic            last;
    } t_in_item;

    typedef struct packed {
        logic [OUT_W-1:0] min_time;
        logic [OUT_W-1:0] q1_time;
        logic [OUT_W-1:0] median_time;
        logic [OUT_W-1:0] q3_time;
        logic             valid_res;
        logic             overflow;
    } t_out_item;

    // per-cycle command to every cell of the chain
    typedef struct packed {
        logic ins;
        logic shift;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: sv/sset_cell.sv
`default_nettype none

module sset_cell #(
    parameter int W = 32
) (
    input  wire                   i_clk,
    input  sset_pkg::t_cell_ctl   i_ctl,
    input  wire                   i_occ,
    input  wire                   i_tail,
    input  wire  [W-1:0]          i_sample,
    input  wire  [W-1:0]          i_left_val,
    input  wire                   i_left_gt,
    input  wire  [W-1:0]          i_right_val,
    output logic [W-1:0]          o_val,
    output logic                  o_gt
);

    logic [W-1:0] r_val;
    logic [W-1:0] n_val;
    logic         w_load;

    // held value lies above the incoming sample
    assign o_gt  = i_occ && (r_val > i_sample);
    assign o_val = r_val;

    // insert: take left neighbour if it also moves up, else the sample
    assign w_load = i_ctl.shift || (i_ctl.ins && (o_gt || i_tail));

    always_comb begin
        if (i_ctl.shift) begin
            n_val = i_right_val;
        end else if (i_left_gt) begin
            n_val = i_left_val;
        end else begin
            n_val = i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_val <= n_val;
        end
    end

endmodule

`default_nettype wire

// File: sv/sset_div.sv
`default_nettype none

module sset_div #(
    parameter int NUM_W = 41,
    parameter int DEN_W = 33
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  wire  [NUM_W-1:0]   i_num,
    input  wire  [DEN_W-1:0]   i_den,
    output logic               o_busy,
    output logic               o_done,
    output logic [NUM_W-1:0]   o_quot
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic [DEN_W:0]    w_rem_sh;
    logic [DEN_W:0]    w_diff;
    logic              w_ge;

    // restoring division, one quotient bit per cycle
    assign w_rem_sh = {r_rem, r_num[NUM_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_den};
    assign w_diff   = w_rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_rem_sh[DEN_W-1:0];
        end
    end

    // step count and completion pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(NUM_W);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

`default_nettype wire

// File: sv/sample_set_quartile_stats.sv
`default_nettype none

// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_ready    i_in_data  (sample, last)
// result    out        o_out_valid / i_out_ready  o_out_data (four statistics, flags)
// config    in         psel/penable/pwrite/pready paddr, pwdata, prdata (repeat_count)
//
// Each sample is inserted into the sorted chain of cells in one step. After the last
// sample the chain drains one cell per cycle, then one shared divider forms the four
// statistics at one bit per cycle; no input is taken meanwhile.
// Reset (synchronous, active low) empties the set; the chain itself needs no clearing.
// A waiting result does not stall sample collection, only the hand-over of the next result.

module sample_set_quartile_stats #(
    parameter int MAX_SAMPLES = 64,
    parameter int SAMPLE_BITS = 32,
    parameter int FRAC_BITS   = 8
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  sset_pkg::t_in_item                 i_in_data,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output sset_pkg::t_out_item                o_out_data,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [sset_pkg::PADDR_W-1:0]       paddr,
    input  wire  [sset_pkg::CFG_W-1:0]         pwdata,
    output logic [sset_pkg::CFG_W-1:0]         prdata,
    output logic                               pready
);

    localparam int VAL_W  = (SAMPLE_BITS < sset_pkg::IN_W) ? SAMPLE_BITS : sset_pkg::IN_W;
    localparam int SUM_W  = VAL_W + 1;
    localparam int NUM_W  = SUM_W + FRAC_BITS;
    localparam int DEN_W  = sset_pkg::CFG_W + 1;
    localparam int WIDE_W = (NUM_W > sset_pkg::OUT_W) ? NUM_W : sset_pkg::OUT_W;
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int OUT_W  = sset_pkg::OUT_W;

    typedef enum logic [3:0] {
        ST_COLLECT = 4'b0001,
        ST_DRAIN   = 4'b0010,
        ST_DIVIDE  = 4'b0100,
        ST_DONE    = 4'b1000
    } t_state;

    t_state                   r_state;
    logic [CNT_W-1:0]         r_cnt;
    logic [CNT_W-1:0]         r_k;
    logic                     r_dropped;
    logic                     r_calc;
    logic [sset_pkg::CFG_W-1:0] r_rc;
    logic [SUM_W-1:0]         r_acc [sset_pkg::N_STATS];
    logic [OUT_W-1:0]         r_res [sset_pkg::N_STATS];
    logic [1:0]               r_j;
    logic                     r_start;
    logic                     r_out_valid;
    sset_pkg::t_out_item      r_out;

    logic                     w_in_xfer;
    logic                     w_out_xfer;
    logic                     w_room;
    logic [CNT_W-1:0]         w_cnt_after;
    logic                     w_out_free;
    sset_pkg::t_cell_ctl      w_ctl;
    logic [VAL_W-1:0]         w_sample;
    logic [VAL_W-1:0]         w_val [MAX_SAMPLES];
    logic                     w_gt  [MAX_SAMPLES];
    logic [VAL_W-1:0]         w_head;
    logic [CNT_W-1:0]         w_ia  [sset_pkg::N_STATS];
    logic [CNT_W-1:0]         w_ib  [sset_pkg::N_STATS];
    logic [CNT_W-1:0]         w_half;
    logic [CNT_W-1:0]         w_qtr;
    logic [CNT_W-1:0]         w_up_len;
    logic [CNT_W-1:0]         w_up_mid;
    logic                     w_div_busy;
    logic                     w_div_done;
    logic [NUM_W-1:0]         w_quot;
    logic [WIDE_W-1:0]        w_wide;
    logic [OUT_W-1:0]         w_fixed;

    // handshakes
    assign o_in_ready  = (r_state == ST_COLLECT);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_out_xfer  = r_out_valid && i_out_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_room      = r_cnt < CNT_W'(MAX_SAMPLES);
    assign w_cnt_after = w_room ? (r_cnt + CNT_W'(1)) : r_cnt;
    assign w_sample    = i_in_data.sample[VAL_W-1:0];

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == sset_pkg::REG_REPEAT_COUNT) ? r_rc : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc <= sset_pkg::CFG_W'(1);
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == sset_pkg::REG_REPEAT_COUNT)) begin
            r_rc <= pwdata;
        end
    end

    // chain commands
    assign w_ctl.ins   = w_in_xfer && w_room;
    assign w_ctl.shift = (r_state == ST_DRAIN);

    // sorted chain of cells, smallest at cell 0
    for (genvar gi = 0; gi < MAX_SAMPLES; gi++) begin : g_cell
        logic [VAL_W-1:0] w_left;
        logic             w_lgt;
        logic [VAL_W-1:0] w_right;
        if (gi == 0) begin : g_first
            assign w_left = w_sample;
            assign w_lgt  = 1'b0;
        end else begin : g_mid
            assign w_left = w_val[gi-1];
            assign w_lgt  = w_gt[gi-1];
        end
        if (gi == MAX_SAMPLES - 1) begin : g_end
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_val[gi+1];
        end
        sset_cell #(
            .W (VAL_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occ       (r_cnt > CNT_W'(gi)),
            .i_tail      (r_cnt == CNT_W'(gi)),
            .i_sample    (w_sample),
            .i_left_val  (w_left),
            .i_left_gt   (w_lgt),
            .i_right_val (w_right),
            .o_val       (w_val[gi]),
            .o_gt        (w_gt[gi])
        );
    end

    assign w_head = w_val[0];

    // positions of the samples that make up each statistic
    assign w_half   = r_cnt >> 1;
    assign w_qtr    = w_half >> 1;
    assign w_up_len = r_cnt - w_half;
    assign w_up_mid = w_half + (w_up_len >> 1);

    always_comb begin
        w_ia[sset_pkg::STAT_MIN] = '0;
        w_ib[sset_pkg::STAT_MIN] = '0;
        // whole set
        w_ib[sset_pkg::STAT_MED] = w_half;
        w_ia[sset_pkg::STAT_MED] = r_cnt[0] ? w_half : (w_half - CNT_W'(1));
        // lower half, a single sample stands for every statistic
        if (r_cnt == CNT_W'(1)) begin
            w_ia[sset_pkg::STAT_Q1] = '0;
            w_ib[sset_pkg::STAT_Q1] = '0;
        end else begin
            w_ib[sset_pkg::STAT_Q1] = w_qtr;
            w_ia[sset_pkg::STAT_Q1] = w_half[0] ? w_qtr : (w_qtr - CNT_W'(1));
        end
        // upper half, holds the middle sample for an odd count
        w_ib[sset_pkg::STAT_Q3] = w_up_mid;
        w_ia[sset_pkg::STAT_Q3] = w_up_len[0] ? w_up_mid : (w_up_mid - CNT_W'(1));
    end

    // shared divider: floor(twice_stat * 2^FRAC_BITS / (2 * repeat_count))
    sset_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_num   ({r_acc[r_j], {FRAC_BITS{1'b0}}}),
        .i_den   ({r_rc, 1'b0}),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // saturate to the output width
    assign w_wide  = WIDE_W'(w_quot);
    assign w_fixed = ((w_wide >> OUT_W) != '0) ? '1 : w_wide[OUT_W-1:0];

    // accumulate the drained samples and collect quotients
    always_ff @(posedge i_clk) begin
        if (w_in_xfer && i_in_data.last) begin
            for (int j = 0; j < sset_pkg::N_STATS; j++) begin
                r_acc[j] <= '0;
            end
        end else if (r_state == ST_DRAIN) begin
            for (int j = 0; j < sset_pkg::N_STATS; j++) begin
                r_acc[j] <= r_acc[j]
                    + ((r_k == w_ia[j]) ? SUM_W'(w_head) : '0)
                    + ((r_k == w_ib[j]) ? SUM_W'(w_head) : '0);
            end
        end
        if (w_div_done) begin
            r_res[r_j] <= w_fixed;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_COLLECT;
            r_cnt     <= '0;
            r_k       <= '0;
            r_j       <= '0;
            r_start   <= 1'b0;
            r_dropped <= 1'b0;
            r_calc    <= 1'b0;
        end else begin
            r_start <= 1'b0;
            case (r_state)
                ST_COLLECT: begin
                    if (w_in_xfer) begin
                        r_cnt <= w_cnt_after;
                        if (!w_room) begin
                            r_dropped <= 1'b1;
                        end
                        if (i_in_data.last) begin
                            r_k    <= '0;
                            r_calc <= (r_rc != '0) && (w_cnt_after != '0);
                            if ((r_rc != '0) && (w_cnt_after != '0)) begin
                                r_state <= ST_DRAIN;
                            end else begin
                                r_state <= ST_DONE;
                            end
                        end
                    end
                end
                ST_DRAIN: begin
                    r_k <= r_k + CNT_W'(1);
                    if (r_k == r_cnt - CNT_W'(1)) begin
                        r_j     <= sset_pkg::STAT_MIN;
                        r_start <= 1'b1;
                        r_state <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE: begin
                    if (w_div_done) begin
                        if (r_j == sset_pkg::STAT_Q3) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_j     <= r_j + 2'd1;
                            r_start <= 1'b1;
                        end
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_cnt     <= '0;
                        r_dropped <= 1'b0;
                        r_state   <= ST_COLLECT;
                    end
                end
                default: begin
                    r_state <= ST_COLLECT;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (w_out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && w_out_free) begin
            r_out.min_time    <= r_calc ? r_res[sset_pkg::STAT_MIN] : '0;
            r_out.q1_time     <= r_calc ? r_res[sset_pkg::STAT_Q1]  : '0;
            r_out.median_time <= r_calc ? r_res[sset_pkg::STAT_MED] : '0;
            r_out.q3_time     <= r_calc ? r_res[sset_pkg::STAT_Q3]  : '0;
            r_out.valid_res   <= r_calc;
            r_out.overflow    <= r_dropped;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_SAMPLES))
        else $error("sample count beyond capacity");

    a_last_stops_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_in_data.last) |=> !o_in_ready)
        else $error("input still taken after the last sample");

    a_div_idle_collect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_div_busy)
        else $error("divider busy while collecting");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.valid_res) |->
            (o_out_data.min_time == '0) && (o_out_data.median_time == '0)
            && (o_out_data.q1_time == '0) && (o_out_data.q3_time == '0))
        else $error("statistics set on an invalid result");
`endif

endmodule

`default_nettype wire

// File: dv/tb_sample_set_quartile_stats.sv
`timescale 1ns / 1ps

module tb_sample_set_quartile_stats;

    localparam int CAPACITY   = 64;
    localparam int FRAC_BITS  = 8;
    localparam int RES_W      = sset_pkg::OUT_W;
    // drain of a full chain plus four divisions, with some margin
    localparam int SETTLE_CYCLES = CAPACITY + 4 * (32 + FRAC_BITS + 3) + 16;
    localparam int STUCK_LIMIT   = 20000;
    localparam int LONG_HOLD     = 700;
    localparam logic [sset_pkg::PADDR_W-1:0] REPEAT_COUNT_ADDR =
        {sset_pkg::REG_REPEAT_COUNT, 2'b00};

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    sset_pkg::t_in_item           in_data = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    sset_pkg::t_out_item          out_data;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [sset_pkg::PADDR_W-1:0] paddr = '0;
    logic [sset_pkg::CFG_W-1:0]   pwdata = '0;
    logic [sset_pkg::CFG_W-1:0]   prdata;
    logic                         pready;

    // predictor state
    logic [sset_pkg::IN_W-1:0]    held_samples[$];
    logic                         held_dropped = 1'b0;
    logic [sset_pkg::CFG_W-1:0]   repeat_cfg = 32'd1;
    sset_pkg::t_out_item          stats_due[$];

    int                 err_cnt = 0;
    int                 items_sent = 0;
    bit                 sender_idle_on = 1'b1;
    bit                 recv_idle_on = 1'b1;
    int                 hold_req = 0;
    int                 hold_cnt = 0;
    int                 stall_cnt = 0;
    int                 idle_cycles = 0;

    sample_set_quartile_stats i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // twice the median of held_samples[lo..hi)
    function automatic logic [sset_pkg::IN_W:0] twice_median(input int lo, input int hi);
        int mid;
        mid = lo + (hi - lo) / 2;
        if (((hi - lo) % 2) == 0)
            return {1'b0, held_samples[mid-1]} + {1'b0, held_samples[mid]};
        return {held_samples[mid], 1'b0};
    endfunction

    // floor(twice_val * 2^FRAC_BITS / (2 * repeat count)), saturating
    function automatic logic [RES_W-1:0] ticks_to_fixed(
        input logic [sset_pkg::IN_W:0] twice_val);
        logic [63:0] divisor;
        logic [63:0] quot;
        logic [63:0] rem;
        logic [63:0] full;
        divisor = {31'd0, repeat_cfg, 1'b0};
        quot    = 64'(twice_val) / divisor;
        rem     = 64'(twice_val) % divisor;
        if ((quot >> (RES_W - FRAC_BITS)) != 0)
            return '1;
        full = (quot << FRAC_BITS) + ((rem << FRAC_BITS) / divisor);
        return full[RES_W-1:0];
    endfunction

    // sorted insert, and the four statistics when the set closes
    function automatic void predict_sample(input logic [sset_pkg::IN_W-1:0] value,
                                           input logic is_last);
        int                  pos;
        int                  n;
        sset_pkg::t_out_item stats;
        if (held_samples.size() < CAPACITY) begin
            pos = held_samples.size();
            while (pos > 0 && held_samples[pos-1] > value)
                pos--;
            held_samples.insert(pos, value);
        end else begin
            held_dropped = 1'b1;
        end
        if (!is_last)
            return;
        n     = held_samples.size();
        stats = '0;
        if (repeat_cfg != 0 && n > 0) begin
            stats.valid_res   = 1'b1;
            stats.min_time    = ticks_to_fixed({held_samples[0], 1'b0});
            stats.median_time = ticks_to_fixed(twice_median(0, n));
            if (n == 1) begin
                stats.q1_time = stats.median_time;
                stats.q3_time = stats.median_time;
            end else begin
                stats.q1_time = ticks_to_fixed(twice_median(0, n / 2));
                stats.q3_time = ticks_to_fixed(twice_median(n / 2, n));
            end
        end
        stats.overflow = held_dropped;
        stats_due.push_back(stats);
        held_samples.delete();
        held_dropped = 1'b0;
    endfunction

    // offer one sample, with an optional idle burst first
    task automatic send_sample(input logic [sset_pkg::IN_W-1:0] value, input logic is_last);
        if (sender_idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{sample: value, last: is_last};
        do @(posedge clk); while (!in_ready);
        predict_sample(value, is_last);
        items_sent++;
    endtask

    // stop offering, let every result arrive and the block go quiet
    task automatic settle_block();
        in_valid <= 1'b0;
        while (stats_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_repeat_count(input logic [sset_pkg::CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REPEAT_COUNT_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        repeat_cfg = value;
    endtask

    function automatic logic [sset_pkg::IN_W-1:0] pick_sample(
        input logic [sset_pkg::IN_W-1:0] prev);
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 55)
            return $urandom;
        if (kind < 70)
            return $urandom_range(0, 255);
        if (kind < 80)
            return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
        if (kind < 90)
            return 32'hFFFF_FF00 | $urandom_range(0, 255);
        return prev;
    endfunction

    // mostly short sets, a few that fill or overrun the store
    function automatic int pick_set_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return $urandom_range(1, 8);
        if (roll < 85)
            return $urandom_range(9, 40);
        if (roll < 95)
            return $urandom_range(41, CAPACITY);
        return $urandom_range(CAPACITY + 1, CAPACITY + 8);
    endfunction

    task automatic send_random_set(input int len);
        logic [sset_pkg::IN_W-1:0] prev;
        logic [sset_pkg::IN_W-1:0] value;
        prev = $urandom;
        for (int i = 0; i < len; i++) begin
            value = pick_sample(prev);
            send_sample(value, i == len - 1);
            prev = value;
        end
    endtask

    // small sets at both divisor extremes, odd and even counts, ties
    task automatic test_directed();
        send_sample(32'd0, 1'b1);
        send_sample(32'hFFFF_FFFF, 1'b1);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'd0, 1'b1);
        send_sample(32'd5, 1'b0);
        send_sample(32'd1, 1'b0);
        send_sample(32'd3, 1'b1);
        send_sample(32'd9, 1'b0);
        send_sample(32'd2, 1'b0);
        send_sample(32'd7, 1'b0);
        send_sample(32'd4, 1'b1);
        for (int i = 0; i < 5; i++)
            send_sample(32'd6, i == 4);
        settle_block();
        write_repeat_count(32'd0);
        send_sample(32'd3, 1'b0);
        send_sample(32'd8, 1'b1);
        settle_block();
        write_repeat_count(32'hFFFF_FFFF);
        send_sample(32'hFFFF_FFFF, 1'b1);
        send_sample(32'd1, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'd2, 1'b1);
        settle_block();
    endtask

    // exactly full, last sample dropped, several dropped, and dropped with divisor zero
    task automatic test_store_full();
        write_repeat_count(32'd3);
        send_random_set(CAPACITY);
        send_random_set(CAPACITY + 1);
        send_random_set(CAPACITY + 6);
        settle_block();
        write_repeat_count(32'd0);
        send_random_set(CAPACITY + 2);
        settle_block();
    endtask

    // receiver holds off long enough for the input side to back up
    task automatic test_backpressure();
        write_repeat_count($urandom_range(1, 20));
        sender_idle_on = 1'b0;
        hold_req = LONG_HOLD;
        for (int i = 0; i < 8; i++)
            send_random_set(3);
        settle_block();
        sender_idle_on = 1'b1;
    endtask

    // phases under a spread of divisors, idling switched per phase
    task automatic test_random_phases(input int target);
        int                         first;
        int                         phase;
        logic [sset_pkg::CFG_W-1:0] divisor;
        first = items_sent;
        phase = 0;
        while (items_sent - first < target) begin
            case (phase % 6)
                0: divisor = 32'd1;
                1: divisor = $urandom_range(2, 10);
                2: divisor = 32'hFFFF_FFFF;
                3: divisor = $urandom;
                4: divisor = 32'd0;
                default: divisor = $urandom_range(11, 1000);
            endcase
            write_repeat_count(divisor);
            sender_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on   = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(4, 9))
                send_random_set(pick_set_len());
            settle_block();
            phase++;
        end
        sender_idle_on = 1'b1;
        recv_idle_on   = 1'b1;
    endtask

    // closing stretch at full rate on both sides
    task automatic test_full_rate(input int target);
        int first;
        first = items_sent;
        sender_idle_on = 1'b0;
        recv_idle_on   = 1'b0;
        write_repeat_count($urandom_range(1, 50));
        while (items_sent - first < target)
            send_random_set(pick_set_len());
        settle_block();
    endtask

    task automatic check_field(input string name, input logic [RES_W-1:0] want,
                               input logic [RES_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            err_cnt++;
        end
    endtask

    // result side: compare each transfer, then decide ready for the next edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (stats_due.size() == 0) begin
                    $display("%0t: result with none expected, actual %h", $time, out_data);
                    err_cnt++;
                end else begin
                    check_field("min_time", stats_due[0].min_time, out_data.min_time);
                    check_field("q1_time", stats_due[0].q1_time, out_data.q1_time);
                    check_field("median_time", stats_due[0].median_time,
                                out_data.median_time);
                    check_field("q3_time", stats_due[0].q3_time, out_data.q3_time);
                    check_field("valid_res", RES_W'(stats_due[0].valid_res),
                                RES_W'(out_data.valid_res));
                    check_field("overflow", RES_W'(stats_due[0].overflow),
                                RES_W'(out_data.overflow));
                    void'(stats_due.pop_front());
                end
            end
            if (hold_req != 0) begin
                hold_cnt = hold_req;
                hold_req = 0;
            end
            if (hold_cnt != 0) begin
                hold_cnt--;
                out_ready <= 1'b0;
            end else if (stall_cnt != 0) begin
                stall_cnt--;
                out_ready <= 1'b0;
            end else if (recv_idle_on && $urandom_range(0, 7) == 0) begin
                stall_cnt = $urandom_range(1, 18) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (psel && penable && pwrite && pready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= STUCK_LIMIT) begin
                    $display("%0t: watchdog: no transfer for %0d cycles", $time, idle_cycles);
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_store_full();
        test_backpressure();
        test_random_phases(1000);
        test_full_rate(150);
        if (err_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
